/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, switched off while reset is low.
`define PDR_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion sampled on the rising clock edge, also checked during reset.
`define PDR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/pdr_pkg.sv */
package pdr_pkg;

    localparam int DUTY_BITS_DEF = 8;

    localparam logic [15:0] MAX_RPM_RST  = 16'd1000;
    localparam logic [7:0]  MAX_DUTY_RST = 8'd255;
    localparam logic [15:0] STOP_MS_RST  = 16'd1000;

    typedef enum logic [1:0] {
        ACT_TICK,
        ACT_SET,
        ACT_RAMP,
        ACT_STOP
    } t_action;

    typedef enum logic [1:0] {
        REG_MAX_RPM,
        REG_MAX_DUTY,
        REG_STOP_MS
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_MAP,
        S_MAP_START,
        S_MAP_WAIT,
        S_APPLY,
        S_CHECK,
        S_RAMP_START,
        S_RAMP_WAIT,
        S_RAMP_STEP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic load_stop;
        logic tick;
        logic mul_map;
        logic div_map;
        logic set_duty;
        logic ramp_begin;
        logic ramp_finish;
        logic mul_ramp;
        logic div_ramp;
        logic ramp_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic rpm_direct;
        logic ramp_complete;
        logic div_busy;
        logic out_free;
    } t_status;

endpackage

/* hw/rtl/pdr_div.sv */
module pdr_div
    import pdr_pkg::*;
#(
    parameter int NUM_W = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [15:0]      i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [15:0]      r_rem;
    logic [15:0]      r_den;

    logic [16:0] rem_sh;
    logic        fits;
    logic [16:0] rem_sub;

    // One restoring step per cycle, numerator bits shift out as quotient bits shift in.
    always_comb begin
        rem_sh  = {r_rem, r_quo[NUM_W-1]};
        fits    = (rem_sh >= {1'b0, r_den});
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_cnt == CNT_W'(NUM_W - 1))) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_quo <= {r_quo[NUM_W-2:0], fits};
            r_rem <= fits ? rem_sub[15:0] : rem_sh[15:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;

endmodule

/* hw/rtl/pdr_datapath.sv */
module pdr_datapath
    import pdr_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_stat,
    input  logic [15:0]          i_max_rpm,
    input  logic [7:0]           i_max_duty,
    input  logic [15:0]          i_stop_ms,
    input  logic [15:0]          i_rpm,
    input  logic [15:0]          i_ramp_ms,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [DUTY_BITS-1:0] o_duty,
    output logic                 o_ramp_done,
    output logic                 o_ramp_running
);

    localparam int RAMP_W = DUTY_BITS + 16;
    localparam int NUM_W  = (RAMP_W > 24) ? RAMP_W : 24;

    // Architectural state
    logic [DUTY_BITS-1:0] r_duty_now;
    logic                 r_ramp_on;
    logic [DUTY_BITS-1:0] r_ramp_from;
    logic [DUTY_BITS-1:0] r_ramp_to;
    logic [15:0]          r_ramp_length;
    logic [15:0]          r_elapsed;

    // Per-transaction working registers
    logic [15:0]      r_rpm;
    logic [15:0]      r_len;
    logic [NUM_W-1:0] r_prod;
    logic             r_done;

    logic                 r_out_valid;
    logic [DUTY_BITS-1:0] r_out_duty;
    logic                 r_out_done;
    logic                 r_out_running;

    logic                 div_busy;
    logic [NUM_W-1:0]     div_quot;
    logic [15:0]          div_den;
    logic                 rpm_zero;
    logic                 rpm_sat;
    logic [DUTY_BITS-1:0] target;
    logic [23:0]          map_prod;
    logic                 ramp_up;
    logic [DUTY_BITS-1:0] span;
    logic [RAMP_W-1:0]    ramp_prod;
    logic [DUTY_BITS-1:0] offset;
    logic                 new_ramp;

    always_comb begin
        rpm_zero  = (r_rpm == 16'd0);
        rpm_sat   = (r_rpm >= i_max_rpm);
        if (rpm_zero) begin
            target = '0;
        end else if (rpm_sat) begin
            target = DUTY_BITS'(i_max_duty);
        end else begin
            target = div_quot[DUTY_BITS-1:0];
        end
        map_prod  = 24'(r_rpm) * 24'(i_max_duty);
        ramp_up   = (r_ramp_to >= r_ramp_from);
        span      = ramp_up ? (r_ramp_to - r_ramp_from) : (r_ramp_from - r_ramp_to);
        ramp_prod = RAMP_W'(span) * RAMP_W'(r_elapsed);
        offset    = div_quot[DUTY_BITS-1:0];
        new_ramp  = !r_ramp_on || (r_ramp_to != target);
        div_den   = i_cmd.div_ramp ? r_ramp_length : i_max_rpm;
    end

    pdr_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_map | i_cmd.div_ramp),
        .i_num   (r_prod),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rpm <= i_rpm;
            r_len <= i_ramp_ms;
        end else if (i_cmd.load_stop) begin
            r_rpm <= 16'd0;
            r_len <= i_stop_ms;
        end
        if (i_cmd.mul_map) begin
            r_prod <= NUM_W'(map_prod);
        end else if (i_cmd.mul_ramp) begin
            r_prod <= NUM_W'(ramp_prod);
        end
        if (i_cmd.ramp_finish) begin
            r_done <= 1'b1;
        end else if (i_cmd.tick || i_cmd.set_duty || i_cmd.ramp_step) begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_now    <= '0;
            r_ramp_on     <= 1'b0;
            r_ramp_from   <= '0;
            r_ramp_to     <= '0;
            r_ramp_length <= '0;
            r_elapsed     <= '0;
        end else begin
            if (i_cmd.tick && (r_elapsed != 16'hFFFF)) begin
                r_elapsed <= r_elapsed + 16'd1;
            end
            if (i_cmd.set_duty) begin
                r_duty_now <= target;
                r_ramp_on  <= 1'b0;
            end
            // A new ramp starts only when none is active or the target moved.
            if (i_cmd.ramp_begin && new_ramp) begin
                r_ramp_on     <= 1'b1;
                r_ramp_from   <= r_duty_now;
                r_ramp_to     <= target;
                r_ramp_length <= r_len;
                r_elapsed     <= '0;
            end
            if (i_cmd.ramp_finish) begin
                r_duty_now <= r_ramp_to;
                r_ramp_on  <= 1'b0;
            end
            if (i_cmd.ramp_step) begin
                r_duty_now <= ramp_up ? (r_ramp_from + offset) : (r_ramp_from - offset);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_duty    <= r_duty_now;
            r_out_done    <= r_done;
            r_out_running <= r_ramp_on;
        end
    end

    always_comb begin
        o_stat.rpm_direct    = rpm_zero || rpm_sat;
        o_stat.ramp_complete = (r_elapsed >= r_ramp_length);
        o_stat.div_busy      = div_busy;
        o_stat.out_free      = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid    = r_out_valid;
    assign o_duty         = r_out_duty;
    assign o_ramp_done    = r_out_done;
    assign o_ramp_running = r_out_running;

endmodule

/* hw/rtl/pdr_ctrl.sv */
module pdr_ctrl
    import pdr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_action,
    output logic       o_in_stall,
    output t_cmd       o_cmd,
    input  t_status    i_stat
);

    t_state  r_state;
    t_state  n_state;
    t_action r_action;
    t_action in_action;

    assign in_action = t_action'(i_action);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_action <= in_action;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (in_action == ACT_TICK) ? S_TICK : S_MAP;
                end
            end
            S_TICK: n_state = S_OUT;
            S_MAP: n_state = i_stat.rpm_direct ? S_APPLY : S_MAP_START;
            S_MAP_START: n_state = S_MAP_WAIT;
            S_MAP_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: n_state = (r_action == ACT_SET) ? S_OUT : S_CHECK;
            S_CHECK: n_state = i_stat.ramp_complete ? S_OUT : S_RAMP_START;
            S_RAMP_START: n_state = S_RAMP_WAIT;
            S_RAMP_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_RAMP_STEP;
                end
            end
            S_RAMP_STEP: n_state = S_OUT;
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load      = i_in_valid && (in_action != ACT_STOP);
                o_cmd.load_stop = i_in_valid && (in_action == ACT_STOP);
            end
            S_TICK:       o_cmd.tick    = 1'b1;
            S_MAP:        o_cmd.mul_map = 1'b1;
            S_MAP_START:  o_cmd.div_map = 1'b1;
            S_MAP_WAIT:   o_cmd = '0;
            S_APPLY: begin
                o_cmd.set_duty   = (r_action == ACT_SET);
                o_cmd.ramp_begin = (r_action != ACT_SET);
            end
            S_CHECK: begin
                o_cmd.ramp_finish = i_stat.ramp_complete;
                o_cmd.mul_ramp    = !i_stat.ramp_complete;
            end
            S_RAMP_START: o_cmd.div_ramp  = 1'b1;
            S_RAMP_WAIT:  o_cmd = '0;
            S_RAMP_STEP:  o_cmd.ramp_step = 1'b1;
            S_OUT:        o_cmd.out_load  = i_stat.out_free;
            default:      o_cmd = '0;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* hw/rtl/pwm_duty_linear_ramp_unit.sv */
// A tick result needs no division; a set needs at most the rpm division, and a ramp or stop
// at most the rpm division and a ramp division, each run on the shared bit-serial
// divider, whose numerator is NUM_W = max(24, DUTY_BITS+16) bits wide.
// One transaction is in flight at a time and the next is accepted the cycle after its result
// is loaded; output stalls delay that load.
// Reset is synchronous and active low: duty, ramp state and registers return to defaults.
module pwm_duty_linear_ramp_unit
    import pdr_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_action,
    input  logic [15:0]          i_rpm,
    input  logic [15:0]          i_ramp_ms,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [DUTY_BITS-1:0] o_duty,
    output logic                 o_ramp_done,
    output logic                 o_ramp_running
);

    logic [15:0] r_max_rpm;
    logic [7:0]  r_max_duty;
    logic [15:0] r_stop_ms;
    logic        cfg_wr;
    t_reg        reg_sel;
    t_cmd        cmd;
    t_status     stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rpm  <= MAX_RPM_RST;
            r_max_duty <= MAX_DUTY_RST;
            r_stop_ms  <= STOP_MS_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_MAX_RPM:  r_max_rpm  <= pwdata[15:0];
                REG_MAX_DUTY: r_max_duty <= pwdata[7:0];
                REG_STOP_MS:  r_stop_ms  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_MAX_RPM:  prdata = {16'd0, r_max_rpm};
            REG_MAX_DUTY: prdata = {24'd0, r_max_duty};
            REG_STOP_MS:  prdata = {16'd0, r_stop_ms};
            default:      prdata = '0;
        endcase
    end

    pdr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    pdr_datapath #(
        .DUTY_BITS (DUTY_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_max_rpm      (r_max_rpm),
        .i_max_duty     (r_max_duty),
        .i_stop_ms      (r_stop_ms),
        .i_rpm          (i_rpm),
        .i_ramp_ms      (i_ramp_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_duty         (o_duty),
        .o_ramp_done    (o_ramp_done),
        .o_ramp_running (o_ramp_running)
    );

endmodule

/* hw/rtl/pdr_checker.sv */
`include "assert_macros.svh"

module pdr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_ramp_done,
    input logic o_ramp_running
);

    // A stalled result must stay offered.
    `PDR_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "result dropped while stalled")

    // Only one transaction is in flight, so input stalls right after an accept.
    `PDR_ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "input not stalled after accept")

    // A completed ramp is never reported as still running.
    `PDR_ASSERT_CLK(a_done_not_running, i_clk, i_rst_n, o_out_valid |-> !(o_ramp_done && o_ramp_running), "ramp done and running together")

    `PDR_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind pwm_duty_linear_ramp_unit pdr_checker u_pdr_checker (.*);

/* dv/pwm_duty_ramp_checker.sv */
module pwm_duty_ramp_checker
    import pdr_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic                 i_pready,
    input  logic [3:0]           i_paddr,
    input  logic [31:0]          i_pwdata,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [1:0]           i_action,
    input  logic [15:0]          i_rpm,
    input  logic [15:0]          i_ramp_ms,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [DUTY_BITS-1:0] i_duty,
    input  logic                 i_ramp_done,
    input  logic                 i_ramp_running,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty;
        logic                 done;
        logic                 running;
    } t_duty_result;

    // Register shadows, updated from the configuration port.
    logic [15:0] cfg_max_rpm;
    logic [7:0]  cfg_max_duty;
    logic [15:0] cfg_stop_ms;

    logic [DUTY_BITS-1:0] duty_now;
    logic                 ramp_on;
    logic [DUTY_BITS-1:0] ramp_from;
    logic [DUTY_BITS-1:0] ramp_to;
    logic [15:0]          ramp_length;
    logic [15:0]          elapsed_ms;

    t_duty_result duty_expected_q[$];
    t_duty_result expected_now;
    int           mismatches = 0;

    function automatic logic [DUTY_BITS-1:0] duty_for_rpm(logic [15:0] rpm);
        logic [31:0] prod;
        if (rpm == 16'd0) begin
            return '0;
        end
        // A zero max_rpm also lands here, so no division by zero is made.
        if (rpm >= cfg_max_rpm) begin
            return DUTY_BITS'(cfg_max_duty);
        end
        prod = 32'(rpm) * 32'(cfg_max_duty);
        return DUTY_BITS'(prod / 32'(cfg_max_rpm));
    endfunction

    function automatic logic follow_ramp(logic [15:0] rpm, logic [15:0] len);
        logic [DUTY_BITS-1:0] target;
        logic [31:0]          offset;
        target = duty_for_rpm(rpm);
        if (!ramp_on || ramp_to != target) begin
            ramp_on     = 1'b1;
            ramp_from   = duty_now;
            ramp_to     = target;
            ramp_length = len;
            elapsed_ms  = '0;
        end
        if (elapsed_ms >= ramp_length) begin
            duty_now = ramp_to;
            ramp_on  = 1'b0;
            return 1'b1;
        end
        if (ramp_to >= ramp_from) begin
            offset   = (32'(ramp_to - ramp_from) * 32'(elapsed_ms)) / 32'(ramp_length);
            duty_now = ramp_from + DUTY_BITS'(offset);
        end else begin
            offset   = (32'(ramp_from - ramp_to) * 32'(elapsed_ms)) / 32'(ramp_length);
            duty_now = ramp_from - DUTY_BITS'(offset);
        end
        return 1'b0;
    endfunction

    function automatic t_duty_result apply_command(t_action act, logic [15:0] rpm,
                                                   logic [15:0] len);
        t_duty_result res;
        res.done = 1'b0;
        case (act)
            ACT_TICK: begin
                if (elapsed_ms != 16'hFFFF) elapsed_ms++;
            end
            ACT_SET: begin
                duty_now = duty_for_rpm(rpm);
                ramp_on  = 1'b0;
            end
            ACT_RAMP: begin
                res.done = follow_ramp(rpm, len);
            end
            default: begin
                res.done = follow_ramp(16'd0, cfg_stop_ms);
            end
        endcase
        res.duty    = duty_now;
        res.running = ramp_on;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_max_rpm  = MAX_RPM_RST;
            cfg_max_duty = MAX_DUTY_RST;
            cfg_stop_ms  = STOP_MS_RST;
            duty_now     = '0;
            ramp_on      = 1'b0;
            ramp_from    = '0;
            ramp_to      = '0;
            ramp_length  = '0;
            elapsed_ms   = '0;
            duty_expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg'(i_paddr[3:2]))
                    REG_MAX_RPM:  cfg_max_rpm  = i_pwdata[15:0];
                    REG_MAX_DUTY: cfg_max_duty = i_pwdata[7:0];
                    REG_STOP_MS:  cfg_stop_ms  = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (duty_expected_q.size() == 0) begin
                    $display("%0t: result with no transaction waiting: duty %0d done %0b run %0b",
                             $time, i_duty, i_ramp_done, i_ramp_running);
                    mismatches++;
                end else begin
                    expected_now = duty_expected_q.pop_front();
                    if (i_duty !== expected_now.duty) begin
                        $display("%0t: duty expected %0d actual %0d",
                                 $time, expected_now.duty, i_duty);
                        mismatches++;
                    end
                    if (i_ramp_done !== expected_now.done) begin
                        $display("%0t: ramp_done expected %0b actual %0b",
                                 $time, expected_now.done, i_ramp_done);
                        mismatches++;
                    end
                    if (i_ramp_running !== expected_now.running) begin
                        $display("%0t: ramp_running expected %0b actual %0b",
                                 $time, expected_now.running, i_ramp_running);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                duty_expected_q.push_back(apply_command(t_action'(i_action), i_rpm, i_ramp_ms));
            end
        end
        o_pending    <= duty_expected_q.size();
        o_fail_count <= mismatches;
    end

endmodule

/* dv/tb_pwm_duty_linear_ramp_unit.sv */
module tb_pwm_duty_linear_ramp_unit
    import pdr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int NUM_PHASES = 6;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [3:0]               paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_stall;
    logic [1:0]               action_in;
    logic [15:0]              rpm_in;
    logic [15:0]              ramp_ms_in;
    logic                     out_valid;
    logic                     out_stall;
    logic [DUTY_BITS_DEF-1:0] duty;
    logic                     ramp_done;
    logic                     ramp_running;
    int                       fail_count;
    int                       pending;

    // Shared pacing controls: calm removes all idling, hold_long asks the
    // receiver for one long stall.
    bit          calm = 1'b0;
    bit          hold_long = 1'b0;
    logic [15:0] last_rpm = 16'd0;

    always #1 i_clk = ~i_clk;

    pwm_duty_linear_ramp_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_action       (action_in),
        .i_rpm          (rpm_in),
        .i_ramp_ms      (ramp_ms_in),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_duty         (duty),
        .o_ramp_done    (ramp_done),
        .o_ramp_running (ramp_running)
    );

    pwm_duty_ramp_checker i_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_action       (action_in),
        .i_rpm          (rpm_in),
        .i_ramp_ms      (ramp_ms_in),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_duty         (duty),
        .i_ramp_done    (ramp_done),
        .i_ramp_running (ramp_running),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    task automatic write_reg(t_reg idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic offer(t_action act, logic [15:0] rpm, logic [15:0] ms);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        action_in  <= act;
        rpm_in     <= rpm;
        ramp_ms_in <= ms;
        do @(posedge i_clk); while (in_stall);
    endtask

    // Holds the sender until every predicted result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly ticks and ramp requests that keep their target, so ramps run to completion
    // across ticks; the rest jumps, stops and full-range noise.
    task automatic draw_command(output t_action act, output logic [15:0] rpm,
                                output logic [15:0] ms);
        int sel;
        int pick;
        sel  = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        if (sel < 45) act = ACT_TICK;
        else if (sel < 75) act = ACT_RAMP;
        else if (sel < 87) act = ACT_STOP;
        else act = ACT_SET;
        if (pick < 6) rpm = last_rpm;
        else if (pick < 8) rpm = 16'($urandom_range(0, 2000));
        else if (pick == 8) rpm = 16'($urandom);
        else rpm = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
        if (pick >= 6 && (act == ACT_RAMP || act == ACT_SET)) last_rpm = rpm;
        ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
    endtask

    initial begin : receiver
        int n;
        out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_long) begin
                hold_long = 1'b0;
                n = 300;
            end else if (calm) begin
                n = 0;
            end else begin
                n = $urandom_range(0, 8);
            end
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!out_valid);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_pwm_duty_linear_ramp_unit: FAIL");
        $finish;
    end

    initial begin : stimulus
        t_action     act;
        logic [15:0] rpm;
        logic [15:0] ms;
        logic [15:0] cfg_rpm;
        logic [7:0]  cfg_duty;
        logic [15:0] cfg_stop;
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        action_in  = ACT_TICK;
        rpm_in     = '0;
        ramp_ms_in = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed transactions with the reset register values.
        offer(ACT_SET, 16'd0, 16'd0);
        offer(ACT_SET, 16'hFFFF, 16'hFFFF);
        offer(ACT_SET, 16'd500, 16'd0);
        offer(ACT_RAMP, 16'd1000, 16'd0);
        offer(ACT_RAMP, 16'd0, 16'd4);
        offer(ACT_TICK, 16'hFFFF, 16'hFFFF);
        offer(ACT_RAMP, 16'd0, 16'd9);
        offer(ACT_TICK, 16'd0, 16'd0);
        offer(ACT_TICK, 16'd0, 16'd0);
        offer(ACT_TICK, 16'd0, 16'd0);
        offer(ACT_RAMP, 16'd0, 16'd0);
        offer(ACT_STOP, 16'd0, 16'd0);
        offer(ACT_SET, 16'd999, 16'd0);
        offer(ACT_RAMP, 16'd300, 16'd3);
        offer(ACT_TICK, 16'd0, 16'd0);
        offer(ACT_RAMP, 16'd300, 16'hFFFF);
        offer(ACT_RAMP, 16'd700, 16'd2);
        offer(ACT_TICK, 16'd0, 16'd0);
        offer(ACT_TICK, 16'd0, 16'd0);
        offer(ACT_RAMP, 16'd700, 16'd0);
        offer(ACT_STOP, 16'hFFFF, 16'hFFFF);
        offer(ACT_RAMP, 16'hFFFF, 16'hFFFF);
        offer(ACT_TICK, 16'd0, 16'd0);
        offer(ACT_STOP, 16'd0, 16'd0);
        drain_results();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin cfg_rpm = 16'd1000;  cfg_duty = 8'd255; cfg_stop = 16'd1000;  end
                1: begin cfg_rpm = 16'd1;     cfg_duty = 8'd1;   cfg_stop = 16'd0;     end
                2: begin cfg_rpm = 16'hFFFF;  cfg_duty = 8'd255; cfg_stop = 16'hFFFF;  end
                3: begin cfg_rpm = 16'd0;     cfg_duty = 8'd128; cfg_stop = 16'd5;     end
                default: begin
                    cfg_rpm  = 16'($urandom_range(1, 4000));
                    cfg_duty = 8'($urandom_range(1, 255));
                    cfg_stop = 16'($urandom_range(0, 30));
                end
            endcase
            write_reg(REG_MAX_RPM, 32'(cfg_rpm));
            write_reg(REG_MAX_DUTY, 32'(cfg_duty));
            write_reg(REG_STOP_MS, 32'(cfg_stop));
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                calm = ((k / 40) % 3 == 2);
                if (k == 50 && (ph == 0 || ph == 4)) hold_long = 1'b1;
                draw_command(act, rpm, ms);
                offer(act, rpm, ms);
            end
            calm = 1'b0;
            drain_results();
        end

        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_pwm_duty_linear_ramp_unit: PASS");
        end else begin
            $display("tb_pwm_duty_linear_ramp_unit: FAIL");
        end
        $finish;
    end

endmodule

/* pwm_duty_linear_ramp_unit.f */
+incdir+hw/rtl
hw/rtl/pdr_pkg.sv
hw/rtl/pdr_div.sv
hw/rtl/pdr_datapath.sv
hw/rtl/pdr_ctrl.sv
hw/rtl/pwm_duty_linear_ramp_unit.sv
hw/rtl/pdr_checker.sv
dv/pwm_duty_ramp_checker.sv
dv/tb_pwm_duty_linear_ramp_unit.sv
